// ===== rtl/core/bsew_pkg.sv =====
// shared types, constants and weight table of the edge-weight map
// no dependencies; used by every module and interface of the block except bsew_ram
package bsew_pkg;

   // default geometry limits
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_RADIUS_DEF = 3;

   // field widths fixed by the word formats
   localparam int FRAME_DIM_W = 12;
   localparam int MAP_W       = 8;
   localparam int CODE_W      = 3;
   localparam int WEIGHT_W    = 22;

   // pixel code bits
   localparam int CODE_ALPHA_ZERO = 0;
   localparam int CODE_ALPHA_FULL = 1;
   localparam int CODE_BLUE_SET   = 2;

   // register reset values
   localparam logic [1:0]             MODE_RESET   = 2'd3;
   localparam logic [FRAME_DIM_W-1:0] WIDTH_RESET  = 12'd1024;
   localparam logic [FRAME_DIM_W-1:0] HEIGHT_RESET = 12'd768;

   typedef enum logic [1:0] {
      CSR_RADIUS_MODE  = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_PERIMETER = 2'd0,
      MODE_RING_1    = 2'd1,
      MODE_RING_2    = 2'd2,
      MODE_RING_3    = 2'd3
   } radius_mode_type;

   // control word travelling with the window
   typedef struct packed {
      logic valid;
      logic last;
      logic border;
   } pix_ctl_type;

   // weight in q16 for an offset with min |d| = a and max |d| = b
   function automatic logic [WEIGHT_W-1:0] weight_q16(input logic [1:0] mode,
                                                      input int a, input int b);
      logic [WEIGHT_W-1:0] w;
      w = '0;
      case (mode)
         MODE_RING_1: begin
            if (b == 1) w = (a == 0) ? 22'd1730551 : 22'd2445403;
         end
         MODE_RING_2: begin
            if (b == 1) w = (a == 0) ? 22'd470150 : 22'd664893;
            else if (b == 2 && a == 0) w = 22'd940301;
            else if (b == 2 && a == 1) w = 22'd1051288;
         end
         MODE_RING_3: begin
            if (b == 1) w = (a == 0) ? 22'd198577 : 22'd280830;
            else if (b == 2 && a == 0) w = 22'd397153;
            else if (b == 2 && a == 1) w = 22'd444031;
            else if (b == 2 && a == 2) w = 22'd561660;
            else if (b == 3 && a == 0) w = 22'd595730;
            else if (b == 3 && a == 1) w = 22'd627954;
         end
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/bsew_if.sv =====
// channel interfaces of the edge-weight map: pixel, result and register write
// depends on bsew_pkg for field widths
interface bsew_req_if;
   import bsew_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_alpha;
   logic [7:0] pixel_blue;
   logic       pad;
   modport source(output valid, pixel_alpha, pixel_blue, pad, input ready);
   modport sink(input valid, pixel_alpha, pixel_blue, pad, output ready);
endinterface

interface bsew_rsp_if;
   import bsew_pkg::*;
   logic             valid;
   logic             ready;
   logic [MAP_W-1:0] map_value;
   logic             last_of_frame;
   modport source(output valid, map_value, last_of_frame, input ready);
   modport sink(input valid, map_value, last_of_frame, output ready);
endinterface

interface bsew_csr_if;
   import bsew_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [1:0]             index;
   logic [FRAME_DIM_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/binary_slice_edge_weight_map.sv =====
// edge-weight map of a binary slice, one result word per pixel word
// result for pixel p passes the read, window, adder and queue registers after the
//   word at raster position p + MAX_RADIUS*(width+1) is accepted
// throughput: one word per cycle unless the output queue is full; line buffer read and written back once a cycle
// reset: counters and registers to defaults (mode 3, 1024 x 768); no clearing pass
// depends on bsew_pkg, bsew_if, bsew_line, bsew_calc
module binary_slice_edge_weight_map
   import bsew_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bsew_req_if.sink   req_bus,
   bsew_rsp_if.source rsp_bus,
   bsew_csr_if.sink   csr_bus
);
   localparam int K  = 2 * MAX_RADIUS + 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int EW = (WW > FRAME_DIM_W) ? WW : FRAME_DIM_W;

   logic [1:0]             mode_ff;
   logic [FRAME_DIM_W-1:0] width_ff;
   logic [FRAME_DIM_W-1:0] height_ff;
   logic [WW-1:0]          frame_w;
   logic [FRAME_DIM_W-1:0] frame_h;
   logic                   en;

   pix_ctl_type            ctl;
   logic [K-1:0]           x_ok, y_ok;
   logic [K*K*CODE_W-1:0]  window;
   logic                   push;
   logic [MAP_W-1:0]       push_value;
   logic                   push_last;

   logic [1:0]             cnt_ff, cnt_in;
   logic                   wr_ptr_ff, rd_ptr_ff;
   logic [MAP_W-1:0]       q_value_ff [2];
   logic                   q_last_ff  [2];
   logic                   pop;

   // register writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_RADIUS_MODE:  mode_ff   <= csr_bus.data[1:0];
            CSR_FRAME_WIDTH:  width_ff  <= csr_bus.data;
            CSR_FRAME_HEIGHT: height_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // effective geometry
   always_comb begin
      if (width_ff == '0) begin
         frame_w = WW'(1);
      end else if (EW'(width_ff) > EW'(MAX_WIDTH)) begin
         frame_w = WW'(MAX_WIDTH);
      end else begin
         frame_w = WW'(width_ff);
      end
      frame_h = (height_ff == '0) ? FRAME_DIM_W'(1) : height_ff;
   end

   // the whole pipeline moves while the output queue has a free slot
   assign en            = cnt_ff != 2'd2;
   assign req_bus.ready = en;

   bsew_line #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_RADIUS(MAX_RADIUS)
   ) u_line (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_bus.valid),
      .pixel_alpha(req_bus.pixel_alpha),
      .pixel_blue (req_bus.pixel_blue),
      .pad        (req_bus.pad),
      .frame_w    (frame_w),
      .frame_h    (frame_h),
      .ctl        (ctl),
      .x_ok       (x_ok),
      .y_ok       (y_ok),
      .window     (window)
   );

   bsew_calc #(
      .MAX_RADIUS(MAX_RADIUS)
   ) u_calc (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .mode         (mode_ff),
      .ctl          (ctl),
      .x_ok         (x_ok),
      .y_ok         (y_ok),
      .window       (window),
      .out_valid    (push),
      .map_value    (push_value),
      .last_of_frame(push_last)
   );

   // two-word output queue
   assign pop = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      cnt_in = cnt_ff;
      if ((push && en) && !pop) cnt_in = cnt_ff + 2'd1;
      else if (!(push && en) && pop) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push && en) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push && en) begin
         q_value_ff[wr_ptr_ff] <= push_value;
         q_last_ff[wr_ptr_ff]  <= push_last;
      end
   end

   assign rsp_bus.valid         = cnt_ff != 2'd0;
   assign rsp_bus.map_value     = q_value_ff[rd_ptr_ff];
   assign rsp_bus.last_of_frame = q_last_ff[rd_ptr_ff];

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output queue overflow");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> cnt_ff != 2'd0)
      else $error("stall without queued words");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers out of step");
endmodule

// ===== rtl/core/bsew_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module bsew_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ===== rtl/core/bsew_line.sv =====
// raster counters, line buffer with read-modify-write of column stacks,
// and the square window of pixel codes; depends on bsew_pkg and bsew_ram
module bsew_line
   import bsew_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          en,
   input  logic                                          in_valid,
   input  logic [7:0]                                    pixel_alpha,
   input  logic [7:0]                                    pixel_blue,
   input  logic                                          pad,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]                frame_w,
   input  logic [FRAME_DIM_W-1:0]                        frame_h,
   output pix_ctl_type                                   ctl,
   output logic [2*MAX_RADIUS:0]                         x_ok,
   output logic [2*MAX_RADIUS:0]                         y_ok,
   output logic [(2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)*CODE_W-1:0] window
);
   localparam int K     = 2 * MAX_RADIUS + 1;
   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int LW    = $clog2(MAX_RADIUS * (MAX_WIDTH + 1) + 1);
   localparam int RW    = FRAME_DIM_W + 1;
   localparam int RAM_W = CODE_W * 2 * MAX_RADIUS;
   localparam int COL_W = CODE_W * K;
   localparam int XS    = AW + 2;
   localparam int YS    = FRAME_DIM_W + 2;

   // raster position of the next word and of the next result
   logic [AW-1:0]          col_ff, col_in;
   logic [RW-1:0]          row_ff, row_in;
   logic [LW-1:0]          lag_ff, lag_in;
   logic [AW-1:0]          ox_ff, ox_in;
   logic [FRAME_DIM_W-1:0] oy_ff, oy_in;

   // read stage
   logic                   s1_valid_ff;
   logic [CODE_W-1:0]      s1_code_ff;
   logic [AW-1:0]          s1_col_ff;
   logic                   s1_emit_ff;
   logic                   s1_last_ff;
   logic [AW-1:0]          s1_ox_ff;
   logic [FRAME_DIM_W-1:0] s1_oy_ff;
   logic                   fwd_ff;
   logic [RAM_W-1:0]       fwd_data_ff;

   // window stage
   logic [K*COL_W-1:0]     window_ff;
   pix_ctl_type            s2_ctl_ff, s2_ctl_in;
   logic [K-1:0]           s2_x_ok_ff, s2_x_ok_in;
   logic [K-1:0]           s2_y_ok_ff, s2_y_ok_in;

   logic [LW-1:0]          lag_len;
   logic                   emit, last, accept, col_wrap, ox_wrap;
   logic [WW-1:0]          col_inc, ox_inc;
   logic [CODE_W-1:0]      code;
   logic [RAM_W-1:0]       rd_data, above;
   logic [COL_W-1:0]       column;

   assign accept  = en && in_valid;
   assign lag_len = LW'(MAX_RADIUS) * (LW'(frame_w) + LW'(1));
   assign emit    = lag_ff >= lag_len;
   assign last    = emit && (WW'(ox_ff) == frame_w - WW'(1))
                    && (oy_ff == frame_h - FRAME_DIM_W'(1));
   assign col_inc  = WW'(col_ff) + WW'(1);
   assign col_wrap = col_inc >= frame_w;
   assign ox_inc   = WW'(ox_ff) + WW'(1);
   assign ox_wrap  = ox_inc >= frame_w;

   // pixel code; rows past the frame store nothing useful
   always_comb begin
      code = '0;
      if (row_ff < RW'(frame_h)) begin
         if (pad) begin
            code[CODE_ALPHA_ZERO] = 1'b1;
         end else begin
            code[CODE_ALPHA_ZERO] = pixel_alpha == 8'd0;
            code[CODE_ALPHA_FULL] = pixel_alpha == 8'hFF;
            code[CODE_BLUE_SET]   = pixel_blue != 8'd0;
         end
      end
   end

   // next raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      lag_in = lag_ff;
      ox_in  = ox_ff;
      oy_in  = oy_ff;
      if (accept) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
            lag_in = '0;
            ox_in  = '0;
            oy_in  = '0;
         end else begin
            col_in = col_wrap ? '0 : col_inc[AW-1:0];
            row_in = col_wrap ? row_ff + RW'(1) : row_ff;
            if (emit) begin
               ox_in = ox_wrap ? '0 : ox_inc[AW-1:0];
               oy_in = ox_wrap ? oy_ff + FRAME_DIM_W'(1) : oy_ff;
            end else begin
               lag_in = lag_ff + LW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         lag_ff <= '0;
         ox_ff  <= '0;
         oy_ff  <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         lag_ff <= lag_in;
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
      end
   end

   // line buffer: each entry holds the codes of the last rows at one column
   bsew_ram #(
      .WIDTH(RAM_W),
      .DEPTH(MAX_WIDTH)
   ) u_rows (
      .clock  (clock),
      .wr_en  (en && s1_valid_ff),
      .wr_addr(s1_col_ff),
      .wr_data(column[RAM_W-1:0]),
      .rd_en  (en),
      .rd_addr(col_ff),
      .rd_data(rd_data)
   );

   // column stack: new code on top, older rows below; forward on back-to-back hit
   assign above  = fwd_ff ? fwd_data_ff : rd_data;
   assign column = {above, s1_code_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s1_emit_ff  <= accept && emit;
         fwd_ff      <= in_valid && s1_valid_ff && (col_ff == s1_col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_code_ff  <= code;
         s1_col_ff   <= col_ff;
         s1_last_ff  <= last;
         s1_ox_ff    <= ox_ff;
         s1_oy_ff    <= oy_ff;
         fwd_data_ff <= column[RAM_W-1:0];
      end
   end

   // frame bounds of each window column and row around the result pixel
   always_comb begin
      logic signed [XS-1:0] xs;
      logic signed [YS-1:0] ys;
      for (int k = 0; k < K; k++) begin
         xs = $signed({2'b00, s1_ox_ff}) + XS'(k - MAX_RADIUS);
         s2_x_ok_in[k] = (xs >= 0) && (xs < $signed({(XS - WW)'(0), frame_w}));
         ys = $signed({2'b00, s1_oy_ff}) + YS'(MAX_RADIUS - k);
         s2_y_ok_in[k] = (ys >= 0) && (ys < $signed({2'b00, frame_h}));
      end
      s2_ctl_in.valid  = s1_valid_ff && s1_emit_ff;
      s2_ctl_in.last   = s1_last_ff;
      s2_ctl_in.border = (s1_ox_ff == '0) || (s1_oy_ff == '0)
                         || (WW'(s1_ox_ff) == frame_w - WW'(1))
                         || (s1_oy_ff == frame_h - FRAME_DIM_W'(1));
   end

   // window shift, newest column at the top slot
   always_ff @(posedge clock) begin
      if (en && s1_valid_ff) begin
         window_ff <= {column, window_ff[K*COL_W-1:COL_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (en) begin
         s2_ctl_ff <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_x_ok_ff <= s2_x_ok_in;
         s2_y_ok_ff <= s2_y_ok_in;
      end
   end

   assign ctl    = s2_ctl_ff;
   assign x_ok   = s2_x_ok_ff;
   assign y_ok   = s2_y_ok_ff;
   assign window = window_ff;

   // a result is only scheduled for a word that was accepted
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      s1_emit_ff |-> s1_valid_ff)
      else $error("result scheduled without a word");

   // row counter stays within the frame plus the flush rows
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      accept && !last |=> row_ff <= RW'(frame_h) + RW'(MAX_RADIUS + 2)
                          || !$stable(frame_h))
      else $error("row counter ran past the flush");
endmodule

// ===== rtl/core/bsew_calc.sv =====
// weighted count of empty neighbours over the window, then sum and saturate; perimeter mode checks four neighbours
// depends on bsew_pkg
module bsew_calc
   import bsew_pkg::*;
#(
   parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          en,
   input  logic [1:0]                                    mode,
   input  pix_ctl_type                                   ctl,
   input  logic [2*MAX_RADIUS:0]                         x_ok,
   input  logic [2*MAX_RADIUS:0]                         y_ok,
   input  logic [(2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)*CODE_W-1:0] window,
   output logic                                          out_valid,
   output logic [MAP_W-1:0]                              map_value,
   output logic                                          last_of_frame
);
   localparam int K    = 2 * MAX_RADIUS + 1;
   localparam int R    = MAX_RADIUS;
   localparam int RS_W = WEIGHT_W + 3;
   localparam int TS_W = RS_W + 3;

   logic [RS_W-1:0]   row_sum_in [K];
   logic [RS_W-1:0]   row_sum_ff [K];
   logic              s3_valid_ff;
   logic              s3_last_ff, s3_on_ff, s3_hit_ff;
   logic [1:0]        s3_mode_ff;
   logic              on_in, hit_in;
   logic [CODE_W-1:0] center;
   logic [CODE_W-1:0] east, west, north, south;
   logic [TS_W-1:0]   total;
   logic [TS_W-17:0]  whole;

   function automatic logic [CODE_W-1:0] cell_at(input int k, input int i,
         input logic [K*K*CODE_W-1:0] win);
      return win[(k * K + i) * CODE_W +: CODE_W];
   endfunction

   function automatic int iabs(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // one sum per window row of weights of empty, in-frame neighbours
   always_comb begin
      logic [CODE_W-1:0] c;
      int                ax, ay;
      for (int i = 0; i < K; i++) begin
         row_sum_in[i] = '0;
         for (int k = 0; k < K; k++) begin
            c  = cell_at(k, i, window);
            ax = iabs(k - R);
            ay = iabs(R - i);
            if (c[CODE_ALPHA_ZERO] && x_ok[k] && y_ok[i] && (ax != 0 || ay != 0)) begin
               row_sum_in[i] = row_sum_in[i] + RS_W'(weight_q16(mode,
                  (ax < ay) ? ax : ay, (ax < ay) ? ay : ax));
            end
         end
      end
   end

   // centre test and simple perimeter check
   always_comb begin
      center = cell_at(R, R, window);
      east   = cell_at(R + 1, R, window);
      west   = cell_at(R - 1, R, window);
      north  = cell_at(R, R + 1, window);
      south  = cell_at(R, R - 1, window);
      case (mode)
         MODE_PERIMETER: on_in = center[CODE_BLUE_SET];
         MODE_RING_1:    on_in = !center[CODE_ALPHA_ZERO];
         default:        on_in = center[CODE_ALPHA_FULL];
      endcase
      hit_in = ctl.border
               || !east[CODE_BLUE_SET]
               || !west[CODE_BLUE_SET]
               || !north[CODE_BLUE_SET]
               || !south[CODE_BLUE_SET];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_last_ff <= ctl.last;
         s3_on_ff   <= on_in;
         s3_hit_ff  <= hit_in;
         s3_mode_ff <= mode;
         row_sum_ff <= row_sum_in;
      end
   end

   // add the row sums, drop the fraction, saturate
   always_comb begin
      total = '0;
      for (int i = 0; i < K; i++) begin
         total = total + TS_W'(row_sum_ff[i]);
      end
      whole = total[TS_W-1:16];
      if (!s3_on_ff) begin
         map_value = '0;
      end else if (s3_mode_ff == MODE_PERIMETER) begin
         map_value = s3_hit_ff ? '1 : '0;
      end else if (whole > (TS_W - 16)'(255)) begin
         map_value = '1;
      end else begin
         map_value = whole[MAP_W-1:0];
      end
   end

   assign out_valid     = s3_valid_ff;
   assign last_of_frame = s3_last_ff;
endmodule
